// File: hw/rtl/stkstat_pkg.sv
// Shared constants, codes and types of the stack with min/max/mean block.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package stkstat_pkg;

	localparam int DEPTH  = 64;
	localparam int PTR_W  = $clog2(DEPTH);
	localparam int FILL_W = 7;
	localparam int KIND_W = 2;
	localparam int STAT_W = 2;
	localparam int VAL_W  = 32;
	localparam int MEAN_W = 40;
	localparam int FRAC_W = 8;
	// sum of DEPTH signed values never overflows
	localparam int SUM_W  = VAL_W + PTR_W + 1;
	localparam int DIVD_W = SUM_W + FRAC_W;
	localparam int DCNT_W = $clog2(DIVD_W + 1);

	localparam logic [KIND_W-1:0] KIND_PUSH  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_POP   = 2'd1;
	localparam logic [KIND_W-1:0] KIND_QUERY = 2'd2;

	localparam logic [STAT_W-1:0] STAT_OK    = 2'd0;
	localparam logic [STAT_W-1:0] STAT_FULL  = 2'd1;
	localparam logic [STAT_W-1:0] STAT_EMPTY = 2'd2;

	localparam logic [FILL_W-1:0] CAP_RESET = FILL_W'(DEPTH);

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

endpackage

// File: hw/rtl/stkstat_ifs.sv
// Valid/ready channel interfaces: request, response and capacity write.
// Depends on stkstat_pkg.
`timescale 1ns / 1ps

interface stkstat_req_if;
	logic                         valid;
	logic                         ready;
	logic [stkstat_pkg::KIND_W-1:0] kind;
	logic signed [stkstat_pkg::VAL_W-1:0] value;

	modport source (output valid, output kind, output value, input ready);
	modport sink   (input valid, input kind, input value, output ready);
endinterface

interface stkstat_rsp_if;
	logic                                  valid;
	logic                                  ready;
	logic [stkstat_pkg::STAT_W-1:0]        status;
	logic signed [stkstat_pkg::VAL_W-1:0]  popped;
	logic signed [stkstat_pkg::VAL_W-1:0]  minimum;
	logic signed [stkstat_pkg::VAL_W-1:0]  maximum;
	logic signed [stkstat_pkg::MEAN_W-1:0] mean_q8;
	logic [stkstat_pkg::FILL_W-1:0]        fill;

	modport source (output valid, output status, output popped, output minimum,
		output maximum, output mean_q8, output fill, input ready);
	modport sink   (input valid, input status, input popped, input minimum,
		input maximum, input mean_q8, input fill, output ready);
endinterface

interface stkstat_cfg_if;
	logic                           valid;
	logic                           ready;
	logic [stkstat_pkg::FILL_W-1:0] data;

	modport source (output valid, output data, input ready);
	modport sink   (input valid, input data, output ready);
endinterface

// File: hw/rtl/stack_with_min_max_mean_top.sv
// Top level of the LIFO stack with min/max/mean statistics.
// Depends on stkstat_pkg, stkstat_ifs and stkstat_div.
`timescale 1ns / 1ps
//
// Usage:
//   req  : one item per operation (kind: push, pop, query; value for push).
//   rsp  : one item per request: status, popped, minimum, maximum, mean_q8, fill.
//   cfg  : capacity write, always ready; write only while the block is idle.
// Rate: one request at a time; req.ready is high only while the sequencer idles.
//   push, unused kind, empty pop/query: the accept moves the sequencer
//   straight to ST_RESP. pop passes through ST_POPRD first (one registered
//   read of the entry memory). query walks the memory (one entry per cycle
//   through the single read port), then runs the bit-serial divider (one
//   quotient bit per cycle, 47 bits) before ST_RESP.
// Output: rsp fields sit in an output register. A stalled receiver holds
//   them; the next request is still taken, and its result waits in the
//   sequencer until the output register frees up.
// Reset: fill count 0, capacity 64, no response pending. Entry memory is
//   not cleared; only written entries are ever read.

module stack_with_min_max_mean_top (
	input  logic           clk,
	input  logic           arst_n,
	stkstat_req_if.sink    req,
	stkstat_rsp_if.source  rsp,
	stkstat_cfg_if.sink    cfg
);

	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_POPRD = 3'd1;
	localparam logic [2:0] ST_WALK  = 3'd2;
	localparam logic [2:0] ST_DGO   = 3'd3;
	localparam logic [2:0] ST_DWAIT = 3'd4;
	localparam logic [2:0] ST_RESP  = 3'd5;

	localparam int VAL_W  = stkstat_pkg::VAL_W;
	localparam int SUM_W  = stkstat_pkg::SUM_W;
	localparam int FILL_W = stkstat_pkg::FILL_W;
	localparam int PTR_W  = stkstat_pkg::PTR_W;
	localparam int MEAN_W = stkstat_pkg::MEAN_W;

	logic [2:0]                     state_q;
	logic [FILL_W-1:0]              cap_q;
	logic [FILL_W-1:0]              fill_q;
	logic [FILL_W-1:0]              rd_cnt_q;
	logic [FILL_W-1:0]              cons_cnt_q;
	logic                           rd_vld_s1;
	logic                           rsp_vld_q;

	// entry memory, single write / single registered read
	logic [VAL_W-1:0]               mem [stkstat_pkg::DEPTH];
	logic [VAL_W-1:0]               rd_data_q;

	// working result
	logic [stkstat_pkg::STAT_W-1:0] res_status_q;
	logic signed [VAL_W-1:0]        res_popped_q;
	logic signed [VAL_W-1:0]        min_q;
	logic signed [VAL_W-1:0]        max_q;
	logic signed [SUM_W-1:0]        sum_q;
	logic signed [MEAN_W-1:0]       res_mean_q;

	// output register
	logic [stkstat_pkg::STAT_W-1:0] out_status_q;
	logic signed [VAL_W-1:0]        out_popped_q;
	logic signed [VAL_W-1:0]        out_min_q;
	logic signed [VAL_W-1:0]        out_max_q;
	logic signed [MEAN_W-1:0]       out_mean_q;
	logic [FILL_W-1:0]              out_fill_q;

	logic                           req_acc;
	logic                           full;
	logic                           empty;
	logic                           wr_en;
	logic                           rd_en;
	logic [PTR_W-1:0]               rd_addr;
	logic [FILL_W-1:0]              fill_m1;
	logic [FILL_W-1:0]              cons_nx;
	logic signed [VAL_W-1:0]        elem;
	logic signed [SUM_W-1:0]        elem_ext;
	logic                           last_elem;
	logic                           out_free;
	logic                           sum_neg;
	logic [SUM_W-1:0]               sum_mag;
	logic                           div_start;
	stkstat_pkg::div_stat_t         div_stat;
	logic [stkstat_pkg::DIVD_W-1:0] div_quot;
	logic [MEAN_W-1:0]              quot_lo;

	assign req.ready = (state_q == ST_IDLE);
	assign req_acc   = req.valid && req.ready;
	assign cfg.ready = 1'b1;

	assign full    = (fill_q >= cap_q) || (fill_q >= FILL_W'(stkstat_pkg::DEPTH));
	assign empty   = (fill_q == '0);
	assign fill_m1 = fill_q - 1'b1;
	assign wr_en   = req_acc && (req.kind == stkstat_pkg::KIND_PUSH) && !full;

	// read port: pop takes the top entry, query walks from the bottom
	always_comb begin
		rd_en   = 1'b0;
		rd_addr = rd_cnt_q[PTR_W-1:0];
		if (req_acc && (req.kind == stkstat_pkg::KIND_POP) && !empty) begin
			rd_en   = 1'b1;
			rd_addr = fill_m1[PTR_W-1:0];
		end else if ((state_q == ST_WALK) && (rd_cnt_q < fill_q)) begin
			rd_en = 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[fill_q[PTR_W-1:0]] <= req.value;
		end
		if (rd_en) begin
			rd_data_q <= mem[rd_addr];
		end
	end

	// walk datapath: one compare pair and one accumulate per entry
	assign elem      = signed'(rd_data_q);
	assign elem_ext  = {{(SUM_W - VAL_W){elem[VAL_W-1]}}, elem};
	assign cons_nx   = cons_cnt_q + 1'b1;
	assign last_elem = rd_vld_s1 && (cons_nx == fill_q);

	// mean: |sum| * 256 / fill, sign restored afterwards
	assign sum_neg   = sum_q[SUM_W-1];
	assign sum_mag   = sum_neg ? unsigned'(-sum_q) : unsigned'(sum_q);
	assign div_start = (state_q == ST_DGO);
	assign quot_lo   = div_quot[MEAN_W-1:0];

	stkstat_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend ({sum_mag, {stkstat_pkg::FRAC_W{1'b0}}}),
		.divisor  (fill_q),
		.stat     (div_stat),
		.quotient (div_quot)
	);

	assign out_free = !rsp_vld_q || rsp.ready;

	// sequencer and control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_IDLE;
			cap_q      <= stkstat_pkg::CAP_RESET;
			fill_q     <= '0;
			rd_cnt_q   <= '0;
			cons_cnt_q <= '0;
			rd_vld_s1  <= 1'b0;
			rsp_vld_q  <= 1'b0;
		end else begin
			if (cfg.valid) begin
				cap_q <= cfg.data;
			end
			if (rsp_vld_q && rsp.ready) begin
				rsp_vld_q <= 1'b0;
			end
			rd_vld_s1 <= 1'b0;
			unique case (state_q)
				ST_IDLE: begin
					if (req_acc) begin
						state_q    <= ST_RESP;
						rd_cnt_q   <= '0;
						cons_cnt_q <= '0;
						case (req.kind)
							stkstat_pkg::KIND_PUSH: begin
								if (!full) begin
									fill_q <= fill_q + 1'b1;
								end
							end
							stkstat_pkg::KIND_POP: begin
								if (!empty) begin
									fill_q  <= fill_m1;
									state_q <= ST_POPRD;
								end
							end
							stkstat_pkg::KIND_QUERY: begin
								if (!empty) begin
									state_q <= ST_WALK;
								end
							end
							default: begin
							end
						endcase
					end
				end
				ST_POPRD: begin
					state_q <= ST_RESP;
				end
				ST_WALK: begin
					if (rd_en) begin
						rd_cnt_q <= rd_cnt_q + 1'b1;
					end
					rd_vld_s1 <= rd_en;
					if (rd_vld_s1) begin
						cons_cnt_q <= cons_nx;
					end
					if (last_elem) begin
						state_q <= ST_DGO;
					end
				end
				ST_DGO: begin
					state_q <= ST_DWAIT;
				end
				ST_DWAIT: begin
					if (div_stat.done) begin
						state_q <= ST_RESP;
					end
				end
				ST_RESP: begin
					if (out_free) begin
						rsp_vld_q <= 1'b1;
						state_q   <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// result payload
	always_ff @(posedge clk) begin
		if (req_acc) begin
			res_status_q <= stkstat_pkg::STAT_OK;
			res_popped_q <= '0;
			min_q        <= '0;
			max_q        <= '0;
			sum_q        <= '0;
			res_mean_q   <= '0;
			case (req.kind)
				stkstat_pkg::KIND_PUSH: begin
					if (full) begin
						res_status_q <= stkstat_pkg::STAT_FULL;
					end
				end
				stkstat_pkg::KIND_POP, stkstat_pkg::KIND_QUERY: begin
					if (empty) begin
						res_status_q <= stkstat_pkg::STAT_EMPTY;
					end
				end
				default: begin
				end
			endcase
		end
		if (state_q == ST_POPRD) begin
			res_popped_q <= elem;
		end
		if ((state_q == ST_WALK) && rd_vld_s1) begin
			sum_q <= sum_q + elem_ext;
			if ((cons_cnt_q == '0) || (elem < min_q)) begin
				min_q <= elem;
			end
			if ((cons_cnt_q == '0) || (elem > max_q)) begin
				max_q <= elem;
			end
		end
		if ((state_q == ST_DWAIT) && div_stat.done) begin
			res_mean_q <= sum_neg ? signed'(-quot_lo) : signed'(quot_lo);
		end
		if ((state_q == ST_RESP) && out_free) begin
			out_status_q <= res_status_q;
			out_popped_q <= res_popped_q;
			out_min_q    <= min_q;
			out_max_q    <= max_q;
			out_mean_q   <= res_mean_q;
			out_fill_q   <= fill_q;
		end
	end

	assign rsp.valid   = rsp_vld_q;
	assign rsp.status  = out_status_q;
	assign rsp.popped  = out_popped_q;
	assign rsp.minimum = out_min_q;
	assign rsp.maximum = out_max_q;
	assign rsp.mean_q8 = out_mean_q;
	assign rsp.fill    = out_fill_q;

	// fill count never runs past the built depth
	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(stkstat_pkg::DEPTH))
		else $error("fill count beyond depth");

	// an accepted push that fits grows the stack by one
	a_push_grow: assert property (@(posedge clk) disable iff (!arst_n)
		wr_en |=> (fill_q == $past(fill_q) + FILL_W'(1)))
		else $error("push did not advance fill count");

	// divider finishes only while the sequencer waits for it
	a_div_done: assert property (@(posedge clk) disable iff (!arst_n)
		div_stat.done |-> (state_q == ST_DWAIT))
		else $error("divider done outside wait state");

	// a new response is loaded only out of the response state
	a_rsp_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(rsp_vld_q) |-> ($past(state_q) == ST_RESP))
		else $error("response raised outside response state");

endmodule

// File: hw/rtl/stkstat_div.sv
// Restoring divider, one quotient bit per cycle: unsigned sum magnitude by fill count.
// Depends on stkstat_pkg.
`timescale 1ns / 1ps

module stkstat_div (
	input  logic                             clk,
	input  logic                             arst_n,
	input  logic                             start,
	input  logic [stkstat_pkg::DIVD_W-1:0]   dividend,
	input  logic [stkstat_pkg::FILL_W-1:0]   divisor,
	output stkstat_pkg::div_stat_t           stat,
	output logic [stkstat_pkg::DIVD_W-1:0]   quotient
);

	logic [stkstat_pkg::DIVD_W-1:0] dvd_q;
	logic [stkstat_pkg::FILL_W-1:0] rem_q;
	logic [stkstat_pkg::DCNT_W-1:0] cnt_q;
	logic                           busy_q;
	logic                           done_q;
	logic [stkstat_pkg::FILL_W:0]   rem_sh;
	logic [stkstat_pkg::FILL_W:0]   rem_nx;
	logic                           ge;

	// shift in the next dividend bit, subtract if it fits
	always_comb begin
		rem_sh = {rem_q, dvd_q[stkstat_pkg::DIVD_W-1]};
		ge     = rem_sh >= {1'b0, divisor};
		rem_nx = ge ? (rem_sh - {1'b0, divisor}) : rem_sh;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= stkstat_pkg::DCNT_W'(stkstat_pkg::DIVD_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == stkstat_pkg::DCNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			dvd_q <= {dvd_q[stkstat_pkg::DIVD_W-2:0], ge};
			rem_q <= rem_nx[stkstat_pkg::FILL_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = dvd_q;

endmodule

// File: test/tb_stack_with_min_max_mean_top.sv
// Testbench for stack_with_min_max_mean_top: push/pop/query items with a
// scoreboard fed by an in-bench stack predictor. Depends on stkstat_pkg,
// the stkstat channel interfaces and the block's RTL.
`timescale 1ns / 1ps

module tb_stack_with_min_max_mean_top;

	localparam int KIND_W = stkstat_pkg::KIND_W;
	localparam int STAT_W = stkstat_pkg::STAT_W;
	localparam int VAL_W  = stkstat_pkg::VAL_W;
	localparam int MEAN_W = stkstat_pkg::MEAN_W;
	localparam int FILL_W = stkstat_pkg::FILL_W;
	localparam int FRAC_W = stkstat_pkg::FRAC_W;
	localparam int DEPTH  = stkstat_pkg::DEPTH;

	// kind 3 is not decoded by the block; it must leave the stack alone
	localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

	localparam int IDLE_PCT      = 12;
	localparam int RESET_CYCLES  = 10;
	localparam int TAIL_CYCLES   = 120;	// longer than a query on a full stack
	localparam int CYCLE_LIMIT   = 500000;
	localparam int REPORT_LIMIT  = 10;
	localparam int PHASE_ITEMS   = 66;

	// one expected response, same field widths as the rsp channel
	typedef struct packed {
		logic [STAT_W-1:0]        status;
		logic signed [VAL_W-1:0]  popped;
		logic signed [VAL_W-1:0]  minimum;
		logic signed [VAL_W-1:0]  maximum;
		logic signed [MEAN_W-1:0] mean_q8;
		logic [FILL_W-1:0]        fill;
	} stack_result_t;

	logic clk;
	logic arst_n;

	stkstat_req_if req_ch();
	stkstat_rsp_if rsp_ch();
	stkstat_cfg_if cfg_ch();

	stack_with_min_max_mean_top dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch),
		.cfg    (cfg_ch)
	);

	// shadow of the stack contents, its depth and the capacity register
	logic signed [VAL_W-1:0] stack_shadow [DEPTH];
	int unsigned             fill_shadow;
	logic [FILL_W-1:0]       cap_shadow;

	stack_result_t expected_results [$];

	int src_idle_pct;
	int sink_idle_pct;
	int cycle_count;
	int mismatch_count;
	int results_seen;
	int n_push, n_full, n_pop, n_query, n_empty, n_unused, n_cfg;

	stack_result_t got;
	stack_result_t want;

	// ------------------------------------------------------------------
	// Clock, watchdog, receiver back-pressure
	// ------------------------------------------------------------------
	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Hard stop if the block hangs or drops a response.
	initial begin
		cycle_count = 0;
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("timeout after %0d cycles, %0d results outstanding",
			cycle_count, expected_results.size());
		$display("tb_stack_with_min_max_mean_top: FAIL");
		$finish;
	end

	// Receiver stalls at random; sink_idle_pct goes to 0 for quiet stretches.
	always @(posedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= sink_idle_pct);
	end

	// ------------------------------------------------------------------
	// Predictor
	// ------------------------------------------------------------------
	// A capacity above the built depth is clamped to the depth.
	function automatic int unsigned effective_cap();
		return (cap_shadow > DEPTH) ? DEPTH : cap_shadow;
	endfunction

	// Applies one operation to the shadow stack and returns the response
	// the block must give for it.
	function automatic stack_result_t predict_op(logic [KIND_W-1:0] k,
		logic signed [VAL_W-1:0] v);
		stack_result_t     r;
		logic signed [VAL_W-1:0] lo, hi;
		longint            sum;
		longint unsigned   mag, quo;
		r = '0;
		case (k)
		stkstat_pkg::KIND_PUSH: begin
			n_push++;
			if (fill_shadow >= effective_cap()) begin
				r.status = stkstat_pkg::STAT_FULL;
				n_full++;
			end else begin
				stack_shadow[fill_shadow] = v;
				fill_shadow++;
			end
		end
		stkstat_pkg::KIND_POP: begin
			n_pop++;
			if (fill_shadow == 0) begin
				r.status = stkstat_pkg::STAT_EMPTY;
				n_empty++;
			end else begin
				fill_shadow--;
				r.popped = stack_shadow[fill_shadow];
			end
		end
		stkstat_pkg::KIND_QUERY: begin
			n_query++;
			if (fill_shadow == 0) begin
				r.status = stkstat_pkg::STAT_EMPTY;
				n_empty++;
			end else begin
				lo  = stack_shadow[0];
				hi  = stack_shadow[0];
				sum = 0;
				for (int i = 0; i < fill_shadow; i++) begin
					if (stack_shadow[i] < lo) lo = stack_shadow[i];
					if (stack_shadow[i] > hi) hi = stack_shadow[i];
					sum += stack_shadow[i];
				end
				// divide the magnitude so the quotient truncates toward zero
				mag = (sum < 0) ? -sum : sum;
				quo = (mag << FRAC_W) / fill_shadow;
				if (sum < 0) quo = -quo;
				r.minimum = lo;
				r.maximum = hi;
				r.mean_q8 = quo[MEAN_W-1:0];
			end
		end
		default: begin
			n_unused++;
		end
		endcase
		r.fill = fill_shadow[FILL_W-1:0];
		return r;
	endfunction

	// ------------------------------------------------------------------
	// Response checker: every accepted rsp item against the oldest
	// expectation, field by field.
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n && rsp_ch.valid && rsp_ch.ready) begin
			got.status  = rsp_ch.status;
			got.popped  = rsp_ch.popped;
			got.minimum = rsp_ch.minimum;
			got.maximum = rsp_ch.maximum;
			got.mean_q8 = rsp_ch.mean_q8;
			got.fill    = rsp_ch.fill;
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= REPORT_LIMIT)
					$display("result %0d arrived with nothing pending: status=%0d fill=%0d",
						results_seen, got.status, got.fill);
			end else begin
				want = expected_results.pop_front();
				if (got.status !== want.status || got.popped !== want.popped ||
						got.minimum !== want.minimum || got.maximum !== want.maximum ||
						got.mean_q8 !== want.mean_q8 || got.fill !== want.fill) begin
					mismatch_count++;
					if (mismatch_count <= REPORT_LIMIT) begin
						$display("result %0d mismatch", results_seen);
						$display("  expected status=%0d popped=%0d min=%0d max=%0d mean_q8=%0d fill=%0d",
							want.status, want.popped, want.minimum, want.maximum,
							want.mean_q8, want.fill);
						$display("  actual   status=%0d popped=%0d min=%0d max=%0d mean_q8=%0d fill=%0d",
							got.status, got.popped, got.minimum, got.maximum,
							got.mean_q8, got.fill);
					end
				end
			end
			results_seen++;
		end
	end

	// ------------------------------------------------------------------
	// Driver tasks. All are entered right after a rising edge.
	// ------------------------------------------------------------------
	// Sends one request item, with random idle cycles ahead of it. valid is
	// left high on return so back-to-back items never drop it in between.
	task automatic send_item(logic [KIND_W-1:0] k, logic signed [VAL_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			req_ch.valid <= 1'b0;
			@(posedge clk);
		end
		req_ch.valid <= 1'b1;
		req_ch.kind  <= k;
		req_ch.value <= v;
		do @(posedge clk); while (!(req_ch.valid && req_ch.ready));
		expected_results.push_back(predict_op(k, v));
	endtask

	// Stops sending and waits until every expected response is back.
	task automatic wait_all_results();
		req_ch.valid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
	endtask

	// Capacity writes only go out with the block drained.
	task automatic write_capacity(logic [FILL_W-1:0] c);
		wait_all_results();
		cfg_ch.valid <= 1'b1;
		cfg_ch.data  <= c;
		do @(posedge clk); while (!(cfg_ch.valid && cfg_ch.ready));
		cap_shadow = c;
		n_cfg++;
		cfg_ch.valid <= 1'b0;
	endtask

	// Mostly uniform, with a fair share of the extremes and small values
	// so min/max ties and small means show up.
	function automatic logic signed [VAL_W-1:0] pick_value();
		case ($urandom_range(9))
		0:       return 32'sh7fffffff;
		1:       return 32'sh80000000;
		2, 3:    return int'($urandom_range(200)) - 100;
		default: return $urandom;
		endcase
	endfunction

	// ------------------------------------------------------------------
	// Tests
	// ------------------------------------------------------------------
	// Pop and query right after reset, plus the undecoded kind.
	task automatic test_empty_stack();
		send_item(stkstat_pkg::KIND_POP, 32'sd12345);
		send_item(stkstat_pkg::KIND_QUERY, -32'sd1);
		send_item(KIND_UNUSED, -32'sd1);
	endtask

	// Extreme values: the max/min pair gives a mean of -0.5, the
	// mixed small set a negative mean that must truncate toward zero.
	task automatic test_extreme_values();
		send_item(stkstat_pkg::KIND_PUSH, 32'sh7fffffff);
		send_item(stkstat_pkg::KIND_PUSH, 32'sh80000000);
		send_item(stkstat_pkg::KIND_QUERY, 32'sd0);
		send_item(stkstat_pkg::KIND_PUSH, -32'sd1);
		send_item(stkstat_pkg::KIND_PUSH, 32'sd0);
		send_item(stkstat_pkg::KIND_PUSH, 32'sd1);
		send_item(stkstat_pkg::KIND_QUERY, 32'sh7fffffff);
		send_item(KIND_UNUSED, 32'sh80000000);
		repeat (5) send_item(stkstat_pkg::KIND_POP, 32'sd0);
	endtask

	// Full check at capacity 1, capacity 0 rejecting all pushes, and a
	// capacity lowered below the current fill.
	task automatic test_capacity_limits();
		write_capacity(7'd1);
		send_item(stkstat_pkg::KIND_PUSH, 32'sd5);
		send_item(stkstat_pkg::KIND_PUSH, 32'sd6);
		write_capacity(7'd0);
		send_item(stkstat_pkg::KIND_PUSH, 32'sd7);
		send_item(stkstat_pkg::KIND_QUERY, 32'sd0);
		write_capacity(7'd2);
		send_item(stkstat_pkg::KIND_PUSH, -32'sd3);
		write_capacity(7'd1);
		send_item(stkstat_pkg::KIND_PUSH, 32'sd4);
		send_item(stkstat_pkg::KIND_POP, 32'sd0);
		send_item(stkstat_pkg::KIND_POP, 32'sd0);
	endtask

	// Random phase at one capacity. Push bursts run past the limit, pop
	// bursts past empty; queries and the odd random kind fall in between.
	task automatic test_random_phase(logic [FILL_W-1:0] c, int n_items,
		bit no_idle, bit pause_midway);
		int sent;
		int mode;
		int len;
		logic [KIND_W-1:0] k;
		sent = 0;
		write_capacity(c);
		if (no_idle) begin
			src_idle_pct  = 0;
			sink_idle_pct = 0;
		end
		while (sent < n_items) begin
			mode = $urandom_range(9);
			if (mode < 4)
				len = $urandom_range(1, effective_cap() + 2);
			else if (mode < 6)
				len = $urandom_range(1, fill_shadow + 2);
			else
				len = 1;
			for (int i = 0; i < len && sent < n_items; i++) begin
				if (mode < 4)      k = stkstat_pkg::KIND_PUSH;
				else if (mode < 6) k = stkstat_pkg::KIND_POP;
				else if (mode < 8) k = stkstat_pkg::KIND_QUERY;
				else               k = KIND_W'($urandom_range(3));
				send_item(k, pick_value());
				sent++;
				// hold the sender once until the pipeline is empty
				if (pause_midway && sent == n_items / 2) wait_all_results();
			end
		end
		src_idle_pct  = IDLE_PCT;
		sink_idle_pct = IDLE_PCT;
	endtask

	// ------------------------------------------------------------------
	// Main sequence
	// ------------------------------------------------------------------
	initial begin
		arst_n         = 1'b0;
		src_idle_pct   = IDLE_PCT;
		sink_idle_pct  = IDLE_PCT;
		mismatch_count = 0;
		results_seen   = 0;
		n_push = 0; n_full = 0; n_pop = 0; n_query = 0;
		n_empty = 0; n_unused = 0; n_cfg = 0;
		fill_shadow = 0;
		cap_shadow  = stkstat_pkg::CAP_RESET;
		req_ch.valid <= 1'b0;
		req_ch.kind  <= stkstat_pkg::KIND_PUSH;
		req_ch.value <= '0;
		cfg_ch.valid <= 1'b0;
		cfg_ch.data  <= '0;
		repeat (RESET_CYCLES) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_stack();
		test_extreme_values();
		test_capacity_limits();

		// reset value, over-range (clamped to depth) with no idling, small caps to
		// hit full often (cap 3 pausing midway), a random one, zero, over-range again
		test_random_phase(7'd64, PHASE_ITEMS, 1'b0, 1'b0);
		test_random_phase(7'd127, PHASE_ITEMS, 1'b1, 1'b0);
		test_random_phase(7'd3, PHASE_ITEMS, 1'b0, 1'b1);
		test_random_phase(7'($urandom_range(1, DEPTH)), PHASE_ITEMS, 1'b0, 1'b0);
		test_random_phase(7'd0, PHASE_ITEMS, 1'b0, 1'b0);
		test_random_phase(7'd100, PHASE_ITEMS, 1'b0, 1'b0);
		test_random_phase(7'd1, PHASE_ITEMS, 1'b0, 1'b0);
		test_random_phase(7'd64, PHASE_ITEMS, 1'b0, 1'b0);

		wait_all_results();
		repeat (TAIL_CYCLES) @(posedge clk);

		$display("covered %0d pushes (%0d rejected full), %0d pops, %0d queries, %0d unused",
			n_push, n_full, n_pop, n_query, n_unused);
		$display("  %0d empty-stack results, %0d capacity writes, %0d results checked, %0d bad",
			n_empty, n_cfg, results_seen, mismatch_count);
		if (mismatch_count == 0 && expected_results.size() == 0) begin
			$display("tb_stack_with_min_max_mean_top: PASS");
		end else begin
			$display("tb_stack_with_min_max_mean_top: FAIL");
		end
		$finish;
	end

endmodule
